>>> src/image_rotate_flip_engine_defines.svh
// assertion macros shared by the image rotate and flip engine
`ifndef IMAGE_ROTATE_FLIP_ENGINE_DEFINES_SVH
`define IMAGE_ROTATE_FLIP_ENGINE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define IRFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IRFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/irfe_pkg.sv
// shared types and constants of the image rotate and flip engine
package irfe_pkg;

	// configuration register sizes
	localparam int CFG_W     = 7;
	localparam int MODE_W    = 3;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSFORM_MODE = 2'd2;

	// transform modes, codes above mirror vertical act as identity
	localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ROT90    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ROT180   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ROT270   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_MIRROR_H = 3'd4;
	localparam logic [MODE_W-1:0] MODE_MIRROR_V = 3'd5;

	// item commands
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// register reset values
	localparam logic [CFG_W-1:0] WIDTH_RESET  = 7'd64;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 7'd64;

	typedef struct packed {
		logic       command;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_end;
	} out_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [CFG_W-1:0]  image_width;
		logic [CFG_W-1:0]  image_height;
		logic [MODE_W-1:0] transform_mode;
	} cfg_t;

	// store access issued for one item
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic last;
	} mem_req_t;

endpackage

>>> src/image_rotate_flip_engine.sv
// Image rotate and flip engine: top level.
// Input channel in_valid/in_stall/in_item carries commands: a write stores the
// next source pixel in raster order, a read returns the next pixel of the
// transformed image in raster order. Reads before a full frame is held and
// writes to a full store are taken and dropped without a result.
// Output channel out_valid/out_stall/out_item carries one result per read,
// with frame_end set on the last pixel, which also empties the store.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx (width,
// height, mode); write only while no item is in flight.
// Throughput is one item per cycle while in_stall is low; a read result passes
// through the synchronous store read register and then the output register
// before it appears. The single store port serves one write or read a cycle.
// Reset clears the position counters and sets a 64 by 64 frame with no
// transform; store contents are undefined until written, no clearing pass.
// A stalled receiver first fills the output register, then the read stage;
// in_stall rises only while both hold a result.
module image_rotate_flip_engine #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [irfe_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [irfe_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  irfe_pkg::in_item_t                 in_item,
	output logic                               out_valid,
	input  logic                               out_stall,
	output irfe_pkg::out_item_t                out_item
);
	import irfe_pkg::*;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);

	cfg_t              cfg_q;
	logic              accept;
	mem_req_t          req;
	logic [ADDR_W-1:0] mem_addr;
	pixel_t            wdata;
	pixel_t            rdata;
	logic              hold;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width    <= WIDTH_RESET;
			cfg_q.image_height   <= HEIGHT_RESET;
			cfg_q.transform_mode <= MODE_NONE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_wdata;
				REG_IMAGE_HEIGHT:   cfg_q.image_height   <= cfg_wdata;
				REG_TRANSFORM_MODE: cfg_q.transform_mode <= cfg_wdata[MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input handshake
	assign in_stall = hold;
	assign accept   = in_valid && !hold;

	irfe_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.accept   (accept),
		.item     (in_item),
		.req      (req),
		.mem_addr (mem_addr),
		.wdata    (wdata)
	);

	irfe_frame_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.wr_en (req.wr_en),
		.rd_en (req.rd_en),
		.addr  (mem_addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	irfe_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (req.rd_en),
		.last      (req.last),
		.rdata     (rdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.hold      (hold)
	);

endmodule

>>> src/irfe_frame_mem.sv
// single port frame store with registered read data
module irfe_frame_mem #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic                  rd_en,
	input  logic [ADDR_W-1:0]     addr,
	input  irfe_pkg::pixel_t      wdata,
	output irfe_pkg::pixel_t      rdata
);
	import irfe_pkg::*;

	pixel_t mem [DEPTH];
	pixel_t rdata_q;

	// one access per cycle, read data holds until the next read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/irfe_ctrl.sv
// position counters and store address generation
`include "image_rotate_flip_engine_defines.svh"

module irfe_ctrl #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	localparam int ADDR_W    = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  irfe_pkg::cfg_t        cfg,
	input  logic                  accept,
	input  irfe_pkg::in_item_t    item,
	output irfe_pkg::mem_req_t    req,
	output logic [ADDR_W-1:0]     mem_addr,
	output irfe_pkg::pixel_t      wdata
);
	import irfe_pkg::*;

	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int POS_W   = $clog2(MAX_DIM);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	logic [DIM_W-1:0]  w;
	logic [DIM_W-1:0]  h;
	logic [DIM_W-1:0]  ow;
	logic [DIM_W-1:0]  oh;
	logic [CNT_W-1:0]  total;
	logic [CNT_W-1:0]  wpos_q;
	logic [POS_W-1:0]  row_q;
	logic [POS_W-1:0]  col_q;
	logic              full;
	logic              col_end;
	logic              row_end;
	logic              last;
	logic [ADDR_W-1:0] wm1;
	logic [ADDR_W-1:0] hm1;
	logic [ADDR_W-1:0] r_a;
	logic [ADDR_W-1:0] c_a;
	logic [ADDR_W-1:0] sr;
	logic [ADDR_W-1:0] sc;
	logic [ADDR_W-1:0] rd_addr;

	// saturate the image size to the store bounds
	always_comb begin
		if (cfg.image_width == '0) begin
			w = DIM_W'(1);
		end else if (32'(cfg.image_width) > MAX_WIDTH) begin
			w = DIM_W'(MAX_WIDTH);
		end else begin
			w = DIM_W'(cfg.image_width);
		end
		if (cfg.image_height == '0) begin
			h = DIM_W'(1);
		end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
			h = DIM_W'(MAX_HEIGHT);
		end else begin
			h = DIM_W'(cfg.image_height);
		end
	end

	// frame size and fill state
	assign total = CNT_W'(w) * CNT_W'(h);
	assign full  = (wpos_q >= total);

	// output image size, swapped for quarter turns
	always_comb begin
		if (cfg.transform_mode == MODE_ROT90 || cfg.transform_mode == MODE_ROT270) begin
			ow = h;
			oh = w;
		end else begin
			ow = w;
			oh = h;
		end
	end

	assign col_end = (32'(col_q) + 32'd1 >= 32'(ow));
	assign row_end = (32'(row_q) + 32'd1 >= 32'(oh));
	assign last    = col_end && row_end;

	// source position of the next output pixel, modulo the store depth
	assign wm1 = ADDR_W'(w) - ADDR_W'(1);
	assign hm1 = ADDR_W'(h) - ADDR_W'(1);
	assign r_a = ADDR_W'(row_q);
	assign c_a = ADDR_W'(col_q);

	always_comb begin
		unique case (cfg.transform_mode)
			MODE_ROT90: begin
				sr = hm1 - c_a;
				sc = r_a;
			end
			MODE_ROT180: begin
				sr = hm1 - r_a;
				sc = wm1 - c_a;
			end
			MODE_ROT270: begin
				sr = c_a;
				sc = wm1 - r_a;
			end
			MODE_MIRROR_H: begin
				sr = r_a;
				sc = wm1 - c_a;
			end
			MODE_MIRROR_V: begin
				sr = hm1 - r_a;
				sc = c_a;
			end
			default: begin
				sr = r_a;
				sc = c_a;
			end
		endcase
	end

	assign rd_addr = sr * ADDR_W'(w) + sc;

	// store request for the accepted item
	assign req.wr_en = accept && (item.command == CMD_WRITE) && !full;
	assign req.rd_en = accept && (item.command == CMD_READ) && full;
	assign req.last  = last;
	assign mem_addr  = req.rd_en ? rd_addr : ADDR_W'(wpos_q);

	assign wdata.red   = item.red_in;
	assign wdata.green = item.green_in;
	assign wdata.blue  = item.blue_in;

	// write counter and output raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else begin
			priority if (req.wr_en) begin
				wpos_q <= wpos_q + CNT_W'(1);
			end else if (req.rd_en) begin
				priority if (last) begin
					wpos_q <= '0;
					row_q  <= '0;
					col_q  <= '0;
				end else if (col_end) begin
					col_q <= '0;
					row_q <= row_q + POS_W'(1);
				end else begin
					col_q <= col_q + POS_W'(1);
				end
			end
		end
	end

	`IRFE_ASSERT_NEXT(a_frame_end_clears, req.rd_en && req.last, wpos_q == '0 && row_q == '0 && col_q == '0, "frame end did not clear the positions")
	`IRFE_ASSERT_NOW(a_wpos_bounded, 1'b1, wpos_q <= CNT_W'(DEPTH), "write count beyond store depth")

endmodule

>>> src/irfe_out_stage.sv
// read data stage and output register
`include "image_rotate_flip_engine_defines.svh"

module irfe_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic                  last,
	input  irfe_pkg::pixel_t      rdata,
	output logic                  out_valid,
	input  logic                  out_stall,
	output irfe_pkg::out_item_t   out_item,
	output logic                  hold
);
	import irfe_pkg::*;

	logic      valid_s1;
	logic      last_s1;
	logic      out_valid_q;
	out_item_t out_item_q;
	logic      out_free;
	logic      s1_move;

	// stage one holds the store read, the output register parts the sides
	assign out_free = !out_valid_q || !out_stall;
	assign s1_move  = valid_s1 && out_free;
	assign hold     = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= load || hold;
			out_valid_q <= s1_move || (out_valid_q && out_stall);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load) begin
			last_s1 <= last;
		end
		if (s1_move) begin
			out_item_q.red_out   <= rdata.red;
			out_item_q.green_out <= rdata.green;
			out_item_q.blue_out  <= rdata.blue;
			out_item_q.frame_end <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`IRFE_ASSERT_NOW(a_no_load_when_blocked, hold, !load, "store read issued while read stage blocked")
	`IRFE_ASSERT_NOW(a_out_from_s1, $rose(out_valid_q), $past(valid_s1), "result without a store read")
	`IRFE_ASSERT_NEXT(a_s1_drains, s1_move && !load, !valid_s1, "read stage kept a moved item")

endmodule
